// File: design/w3f_pkg.sv
// Shared types, register indexes and the median operator function for the 3x3 window filter.
package w3f_pkg;

  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxHeight = 1024;
  localparam int unsigned CfgW         = 11;
  localparam int unsigned DimW         = 11;

  typedef enum logic [1:0] {
    REG_FILTER_MODE  = 2'd0,
    REG_BORDER_MODE  = 2'd1,
    REG_IMAGE_WIDTH  = 2'd2,
    REG_IMAGE_HEIGHT = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    FM_MIN   = 3'd0,
    FM_MAX   = 3'd1,
    FM_MED   = 3'd2,
    FM_MEAN  = 3'd3,
    FM_GAUSS = 3'd4,
    FM_LAP   = 3'd5,
    FM_SOBEL = 3'd6,
    FM_PASS  = 3'd7
  } fmode_t;

  typedef enum logic [1:0] {
    BM_KEEP  = 2'd0,
    BM_PAD   = 2'd1,
    BM_REPL  = 2'd2,
    BM_TRUNC = 2'd3
  } bmode_t;

  // Window plus the tags that travel with one visited output position.
  typedef struct packed {
    logic [8:0][7:0] pix;
    logic            border;
    logic            emit;
    logic            eor;
    logic            eof;
  } win_t;

  // Compare-exchange sort of nine bytes, returns the middle one.
  function automatic logic [7:0] median9(input logic [8:0][7:0] p);
    logic [8:0][7:0] v;
    logic [7:0]      t;
    v = p;
    for (int k = 0; k < 9; k++) begin
      for (int i = (k % 2); i < 8; i += 2) begin
        if (v[i] > v[i+1]) begin
          t      = v[i];
          v[i]   = v[i+1];
          v[i+1] = t;
        end
      end
    end
    return v[4];
  endfunction

endpackage

// File: design/window3x3_image_filter.sv
// Top level of the streaming 3x3 window filter.
//   channel | valid     | stall     | payload
//   in      | in_valid  | in_stall  | action, pixel
//   out     | out_valid | out_stall | pixel_out, end_of_row, end_of_frame
//   cfg     | cfg_we    | -         | cfg_index, cfg_data
// One request at a time. A request that visits no position leaves the FSM idle.
// A visit reads three line-store columns in S_RD0 to S_RD2, fills the window
// through S_RD3 and starts the reducer in S_RED; its result is registered to
// the output. The next request waits for the reducer and for that result to be
// taken (none for a truncated border). Sobel adds a square-root search on n.
// Reset clears counters and window and sets the configuration to its defaults; line stores stay unset.
// A held output stalls the next request.
module window3x3_image_filter import w3f_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [CfgW-1:0] cfg_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            action,
  input  logic [7:0]      pixel,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      pixel_out,
  output logic            end_of_row,
  output logic            end_of_frame
);
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned LW = $clog2(MAX_WIDTH + 4);
  localparam int unsigned PW = CW + RW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_RD3, S_RED
  } st_t;

  st_t st, st_next;
  logic [2:0] filter_mode;
  logic [1:0] border_mode;
  logic [DimW-1:0] image_width, image_height;
  logic [CW:0] w;
  logic [RW:0] h;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= FM_MED;
      border_mode  <= BM_KEEP;
      image_width  <= 11'd1024;
      image_height <= 11'd1024;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FILTER_MODE:  filter_mode  <= cfg_data[2:0];
        REG_BORDER_MODE:  border_mode  <= cfg_data[1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(image_width) < 3) w = (CW+1)'(3);
    else if (32'(image_width) > MAX_WIDTH) w = (CW+1)'(MAX_WIDTH);
    else w = (CW+1)'(image_width);
    if (32'(image_height) < 3) h = (RW+1)'(3);
    else if (32'(image_height) > MAX_HEIGHT) h = (RW+1)'(MAX_HEIGHT);
    else h = (RW+1)'(image_height);
  end

  logic [CW:0] in_col, out_col;
  logic [RW:0] in_row, out_row;
  logic [1:0]  in_slot, out_slot;
  logic [LW-1:0] lead, lead_inc;
  logic [PW-1:0] pos_lin, total;

  logic acc;
  assign acc = in_valid && !in_stall;

  // lead after a new pixel, held at its ceiling
  assign lead_inc = lead + LW'(32'(lead) <= MAX_WIDTH + 2);

  logic visit;
  always_comb begin
    pos_lin = PW'(out_row) * PW'(w) + PW'(out_col);
    total   = PW'(w) * PW'(h);
    if (!action) visit = (32'(lead_inc) > 32'(w) + 1);
    else visit = (lead != '0) && (32'(lead) >= ((pos_lin < total) ? 32'(total - pos_lin) : 1));
  end

  logic [1:0] s_up, s_low;
  assign s_up  = (out_slot == 2'd0) ? 2'd2 : out_slot - 2'd1;
  assign s_low = (out_slot == 2'd2) ? 2'd0 : out_slot + 2'd1;

  logic top_o, bot_o, lft_o, rgt_o;
  assign top_o = (out_row == '0);
  assign bot_o = (32'(out_row) + 1 >= 32'(h));
  assign lft_o = (out_col == '0);
  assign rgt_o = (32'(out_col) + 1 >= 32'(w));

  logic [CW-1:0] rd_col;
  logic rd_en;
  logic [7:0] rd_up, rd_mid, rd_low;
  logic [1:0] rd_cnt;
  logic [8:0][7:0] wpix;
  win_t win;
  logic red_start, red_busy, red_done;
  win_t red_win;
  logic [7:0] red_res;

  always_comb begin
    rd_col = out_col[CW-1:0];
    if (st == S_RD0) rd_col = lft_o ? out_col[CW-1:0] : CW'(out_col - 1);
    if (st == S_RD2) rd_col = rgt_o ? out_col[CW-1:0] : CW'(out_col + 1);
  end
  assign rd_en = (st == S_RD0) || (st == S_RD1) || (st == S_RD2);

  w3f_lines #(.MAX_WIDTH(MAX_WIDTH)) u_lines (
    .clk, .wr_en(acc && !action), .wr_slot(in_slot), .wr_col(in_col[CW-1:0]),
    .wr_data(pixel), .rd_en, .rd_slot_up(s_up), .rd_slot_mid(out_slot),
    .rd_slot_low(s_low), .rd_col, .rd_up, .rd_mid, .rd_low
  );

  // column j arrives in the cycle after its read
  always_ff @(posedge clk) begin
    if (rst) begin
      wpix   <= '0;
      rd_cnt <= '0;
    end else if (st == S_RD1 || st == S_RD2 || st == S_RD3) begin
      for (int i = 0; i < 3; i++) begin
        logic [7:0] v;
        logic outs;
        v = (i == 0) ? rd_up : (i == 1) ? rd_mid : rd_low;
        outs = (i == 0 && top_o) || (i == 2 && bot_o) || (rd_cnt == 2'd0 && lft_o)
            || (rd_cnt == 2'd2 && rgt_o);
        if (i == 0 && top_o) v = rd_mid;
        if (i == 2 && bot_o) v = rd_mid;
        if (outs && bmode_t'(border_mode) == BM_PAD) v = 8'hff;
        wpix[i*3 + 32'(rd_cnt)] <= v;
      end
      rd_cnt <= (st == S_RD3) ? 2'd0 : rd_cnt + 2'd1;
    end
  end

  always_comb begin
    logic brd;
    brd = top_o || bot_o || lft_o || rgt_o;
    win.pix    = wpix;
    win.border = brd;
    if (bmode_t'(border_mode) == BM_TRUNC) begin
      win.emit = !brd;
      win.eor  = 32'(out_col) + 2 >= 32'(w);
      win.eof  = win.eor && (32'(out_row) + 2 >= 32'(h));
    end else begin
      win.emit = 1'b1;
      win.eor  = rgt_o;
      win.eof  = rgt_o && bot_o;
    end
  end

  assign red_start = (st == S_RED) && !red_busy;

  w3f_reduce u_red (
    .clk, .rst, .start(red_start), .win, .filter_mode, .border_mode,
    .busy(red_busy), .done(red_done), .win_q(red_win), .result(red_res)
  );

  logic pend;
  always_comb begin
    st_next = st;
    unique case (st)
      S_IDLE:  if (acc && visit) st_next = S_RD0;
      S_RD0:   st_next = S_RD1;
      S_RD1:   st_next = S_RD2;
      S_RD2:   st_next = S_RD3;
      S_RD3:   st_next = S_RED;
      S_RED:   if (!red_busy) st_next = S_IDLE;
      default: st_next = S_IDLE;
    endcase
  end

  assign in_stall = (st != S_IDLE) || red_busy || pend || out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      in_col <= '0; in_row <= '0; in_slot <= '0;
      out_col <= '0; out_row <= '0; out_slot <= '0;
      lead <= '0;
      out_valid <= 1'b0;
      pend <= 1'b0;
    end else begin
      st <= st_next;
      if (acc && !action) begin
        if (32'(in_col) + 1 >= 32'(w)) begin
          in_col <= '0;
          in_slot <= (in_slot == 2'd2) ? 2'd0 : in_slot + 2'd1;
          in_row <= (32'(in_row) + 1 >= 32'(h)) ? '0 : in_row + 1'b1;
        end else in_col <= in_col + 1'b1;
      end
      if (acc) begin
        lead <= (action ? lead : lead_inc) - LW'(visit);
      end
      if (st == S_RED && !red_busy) begin
        pend <= 1'b1;
        if (32'(out_col) + 1 >= 32'(w)) begin
          out_col <= '0;
          out_slot <= (out_slot == 2'd2) ? 2'd0 : out_slot + 2'd1;
          out_row <= (32'(out_row) + 1 >= 32'(h)) ? '0 : out_row + 1'b1;
        end else out_col <= out_col + 1'b1;
      end
      if (red_done) begin
        pend <= 1'b0;
        if (red_win.emit) begin
          out_valid    <= 1'b1;
          pixel_out    <= red_res;
          end_of_row   <= red_win.eor;
          end_of_frame <= red_win.eof;
        end
      end else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end
endmodule

// File: design/w3f_lines.sv
// Line stores: writes incoming pixels, reads one column of all three rows of the 3x3 neighborhood.
module w3f_lines import w3f_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [1:0]                    wr_slot,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wr_col,
  input  logic [7:0]                    wr_data,
  input  logic                          rd_en,
  input  logic [1:0]                    rd_slot_up,
  input  logic [1:0]                    rd_slot_mid,
  input  logic [1:0]                    rd_slot_low,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_col,
  output logic [7:0]                    rd_up,
  output logic [7:0]                    rd_mid,
  output logic [7:0]                    rd_low
);
  // three rotating rows, one memory each so all three read in the same cycle
  logic [7:0] mem0 [MAX_WIDTH];
  logic [7:0] mem1 [MAX_WIDTH];
  logic [7:0] mem2 [MAX_WIDTH];
  logic [7:0] q0, q1, q2;
  logic [1:0] s_up, s_mid, s_low;

  always_ff @(posedge clk) begin
    if (wr_en && wr_slot == 2'd0) mem0[wr_col] <= wr_data;
    if (wr_en && wr_slot == 2'd1) mem1[wr_col] <= wr_data;
    if (wr_en && wr_slot == 2'd2) mem2[wr_col] <= wr_data;
    if (rd_en) begin
      q0    <= mem0[rd_col];
      q1    <= mem1[rd_col];
      q2    <= mem2[rd_col];
      s_up  <= rd_slot_up;
      s_mid <= rd_slot_mid;
      s_low <= rd_slot_low;
    end
  end

  function automatic logic [7:0] pick(input logic [1:0] s, input logic [7:0] a,
                                      input logic [7:0] b, input logic [7:0] c);
    unique case (s)
      2'd0:    return a;
      2'd1:    return b;
      default: return c;
    endcase
  endfunction

  assign rd_up  = pick(s_up,  q0, q1, q2);
  assign rd_mid = pick(s_mid, q0, q1, q2);
  assign rd_low = pick(s_low, q0, q1, q2);
endmodule

// File: design/w3f_reduce.sv
// Window operators: min, max, median, mean, gaussian, laplacian, sobel magnitude, pass-through.
module w3f_reduce import w3f_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  win_t       win,
  input  logic [2:0] filter_mode,
  input  logic [1:0] border_mode,
  output logic       busy,
  output logic       done,
  output win_t       win_q,
  output logic [7:0] result
);
  // stage 1: sums and gradients
  logic [11:0] s_sum;
  logic [11:0] g_sum;
  logic signed [12:0] lap;
  logic signed [11:0] gx, gy;
  logic signed [21:0] gx_w, gy_w;
  logic [7:0] lo, hi, med;
  logic [7:0] p [9];

  always_comb begin
    for (int i = 0; i < 9; i++) p[i] = win.pix[i];
  end

  always_comb begin
    s_sum = '0;
    lo = 8'hff;
    hi = 8'h00;
    for (int i = 0; i < 9; i++) begin
      s_sum = s_sum + 12'(p[i]);
      if (p[i] < lo) lo = p[i];
      if (p[i] > hi) hi = p[i];
    end
    g_sum = 12'(p[0]) + 12'(p[2]) + 12'(p[6]) + 12'(p[8])
          + ((12'(p[1]) + 12'(p[3]) + 12'(p[5]) + 12'(p[7])) << 1) + (12'(p[4]) << 2);
    lap = 13'(5 * $signed({5'd0, p[4]})) - $signed({5'd0, p[1]}) - $signed({5'd0, p[3]})
        - $signed({5'd0, p[5]}) - $signed({5'd0, p[7]});
    gx = $signed({4'd0, p[6]}) + 12'sd2 * $signed({4'd0, p[7]}) + $signed({4'd0, p[8]})
       - $signed({4'd0, p[0]}) - 12'sd2 * $signed({4'd0, p[1]}) - $signed({4'd0, p[2]});
    gy = $signed({4'd0, p[2]}) + 12'sd2 * $signed({4'd0, p[5]}) + $signed({4'd0, p[8]})
       - $signed({4'd0, p[0]}) - 12'sd2 * $signed({4'd0, p[3]}) - $signed({4'd0, p[6]});
    med = median9(win.pix);
  end

  assign gx_w = 22'(gx);
  assign gy_w = 22'(gy);

  logic [7:0]  r1_simple;
  logic [21:0] q_reg;
  logic        sobel_run;
  logic [8:0]  n, n_next;
  logic        r1_v, r2_v;
  logic [11:0] s_reg;

  // mean via reciprocal: floor(s/9) = (s*7282)>>16 for s < 2296
  logic [7:0] mean_v;
  logic [25:0] mprod;
  assign mprod  = 26'(s_reg) * 26'd7282;
  assign mean_v = mprod[23:16];

  logic [7:0] gq;
  logic [3:0] gr;
  logic [8:0] ground;
  always_comb begin
    gq = g_sum[11:4];
    gr = g_sum[3:0];
    ground = {1'b0, gq};
    if (gr > 4'd8 || (gr == 4'd8 && gq[0])) ground = ground + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      win_q <= win;
      s_reg <= s_sum;
      q_reg <= 22'(gx_w * gx_w + gy_w * gy_w);
      unique case (fmode_t'(filter_mode))
        FM_MIN:   r1_simple <= lo;
        FM_MAX:   r1_simple <= hi;
        FM_MED:   r1_simple <= med;
        FM_GAUSS: r1_simple <= ground[8] ? 8'hff : ground[7:0];
        FM_LAP:   r1_simple <= lap < 0 ? 8'd0 : (lap > 255 ? 8'hff : lap[7:0]);
        default:  r1_simple <= p[4];
      endcase
    end
  end

  // sobel: iterative search n*n+n >= q, one increment a cycle starting from zero
  always_comb begin
    n_next = n + 9'd1;
  end

  logic [18:0] nn;
  assign nn = 19'(n) * 19'(n) + 19'(n);

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_v <= 1'b0;
      r2_v <= 1'b0;
      sobel_run <= 1'b0;
      n <= '0;
    end else begin
      r2_v <= 1'b0;
      r1_v <= start;
      if (r1_v) begin
        if (fmode_t'(filter_mode) == FM_SOBEL && q_reg < 22'd65281) begin
          sobel_run <= 1'b1;
          n <= '0;
        end else begin
          r2_v <= 1'b1;
        end
      end else if (sobel_run) begin
        if (22'(nn) >= q_reg) begin
          sobel_run <= 1'b0;
          r2_v <= 1'b1;
        end else begin
          n <= n_next;
        end
      end
    end
  end

  logic [7:0] pre;
  always_comb begin
    unique case (fmode_t'(filter_mode))
      FM_MEAN:  pre = mean_v;
      FM_SOBEL: pre = (q_reg >= 22'd65281) ? 8'hff : n[7:0];
      default:  pre = r1_simple;
    endcase
    result = (bmode_t'(border_mode) == BM_KEEP && win_q.border) ? win_q.pix[4] : pre;
  end

  assign done = r2_v;
  assign busy = r1_v | sobel_run | r2_v;
endmodule

// File: design/w3f_check.sv
// Port-level checks for the window filter, bound to the top level.
module w3f_check (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [7:0] pixel_out,
  input logic end_of_row,
  input logic end_of_frame
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_out)) else $error("output dropped");
  a_eof: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_frame |-> end_of_row) else $error("frame end off row end");
  a_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("request taken with result pending");
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid) else $error("valid after reset");
endmodule

bind window3x3_image_filter w3f_check u_check (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .pixel_out, .end_of_row, .end_of_frame
);

// File: tb/tb_window3x3_image_filter.sv
// Self-checking testbench for the streaming 3x3 window filter.
`timescale 1ns / 1ps

module tb_window3x3_image_filter;
  import w3f_pkg::*;

  localparam int MaxW = 1024;
  localparam int MaxH = 1024;
  localparam int CycleLimit = 4000000;
  localparam int SettleCycles = 300;

  typedef struct {
    logic [7:0] px;
    logic       eor;
    logic       eof;
  } filt_out_t;

  // Tracks filter state and holds the pixels the block must still deliver.
  class filter_scoreboard;
    int unsigned fmode, bmode, wreg, hreg;
    logic [7:0]  rows [3][MaxW];
    int unsigned in_col, in_row, out_col, out_row, in_slot, out_slot, lead;
    filt_out_t   pend_q[$];
    int          errors;

    function new();
      fmode = FM_MED; bmode = BM_KEEP; wreg = 1024; hreg = 1024;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      in_slot = 0; out_slot = 0; lead = 0; errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, int unsigned v);
      case (idx)
        REG_FILTER_MODE:  fmode = v & 7;
        REG_BORDER_MODE:  bmode = v & 3;
        REG_IMAGE_WIDTH:  wreg = v & 'h7ff;
        default:          hreg = v & 'h7ff;
      endcase
    endfunction

    function int unsigned eff_w();
      return wreg < 3 ? 3 : (wreg > MaxW ? MaxW : wreg);
    endfunction

    function int unsigned eff_h();
      return hreg < 3 ? 3 : (hreg > MaxH ? MaxH : hreg);
    endfunction

    function int unsigned reduce_win(int unsigned p[9]);
      int unsigned v[9];
      int unsigned s, lo, hi, t, g, q;
      int a, b, l, j;
      s = 0; lo = 255; hi = 0; a = 0; b = 0;
      for (int i = 0; i < 9; i++) begin
        s += p[i];
        if (p[i] < lo) lo = p[i];
        if (p[i] > hi) hi = p[i];
      end
      a = -int'(p[0]) - 2 * int'(p[1]) - int'(p[2]) + int'(p[6]) + 2 * int'(p[7]) + int'(p[8]);
      b = -int'(p[0]) + int'(p[2]) - 2 * int'(p[3]) + 2 * int'(p[5]) - int'(p[6]) + int'(p[8]);
      case (fmode)
        FM_MIN: return lo;
        FM_MAX: return hi;
        FM_MED: begin
          v = p;
          for (int i = 1; i < 9; i++) begin
            t = v[i];
            j = i;
            while (j > 0 && v[j-1] > t) begin
              v[j] = v[j-1];
              j--;
            end
            v[j] = t;
          end
          return v[4];
        end
        FM_MEAN: return s / 9;
        FM_GAUSS: begin
          g = p[0] + 2 * p[1] + p[2] + 2 * p[3] + 4 * p[4] + 2 * p[5] + p[6] + 2 * p[7] + p[8];
          q = g >> 4;
          // round half to even
          if ((g & 15) > 8 || ((g & 15) == 8 && q[0])) q++;
          return q > 255 ? 255 : q;
        end
        FM_LAP: begin
          l = 5 * int'(p[4]) - int'(p[1]) - int'(p[3]) - int'(p[5]) - int'(p[7]);
          return l < 0 ? 0 : (l > 255 ? 255 : l);
        end
        FM_SOBEL: begin
          q = a * a + b * b;
          if (q >= 65281) return 255;
          t = 0;
          while (t * t + t < q) t++;
          return t;
        end
        default: return p[4];
      endcase
    endfunction

    function void visit();
      int unsigned w, h, r, c, slot, col, val;
      int unsigned p[9];
      bit border, outside, eor, eof, emit;
      filt_out_t item;
      w = eff_w(); h = eff_h(); r = out_row; c = out_col;
      border = r == 0 || c == 0 || r + 1 >= h || c + 1 >= w;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          outside = 0; slot = out_slot; col = c;
          if (i == 0) begin
            if (r == 0) outside = 1; else slot = out_slot + 2;
          end
          if (i == 2) begin
            if (r + 1 >= h) outside = 1; else slot = out_slot + 1;
          end
          if (j == 0) begin
            if (c == 0) outside = 1; else col = c - 1;
          end
          if (j == 2) begin
            if (c + 1 >= w) outside = 1; else col = c + 1;
          end
          if (outside && bmode == BM_PAD) p[i*3+j] = 255;
          else if (col >= MaxW) p[i*3+j] = 0;
          else p[i*3+j] = rows[slot % 3][col];
        end
      end
      val = reduce_win(p);
      emit = 1;
      if (bmode == BM_KEEP && border) val = p[4];
      if (bmode == BM_TRUNC) begin
        if (border) emit = 0;
        eor = c + 2 >= w;
        eof = eor && r + 2 >= h;
      end else begin
        eor = c + 1 >= w;
        eof = eor && r + 1 >= h;
      end
      if (emit) begin
        item.px = val[7:0];
        item.eor = eor;
        item.eof = eof;
        pend_q.insert(pend_q.size(), item);
      end
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_slot = (out_slot + 1) % 3;
        out_row++;
        if (out_row >= h) out_row = 0;
      end
      if (lead > 0) lead--;
    endfunction

    function void note_request(logic act, logic [7:0] pix);
      int unsigned w, h, total, pos, remain;
      w = eff_w(); h = eff_h();
      if (act == 1'b0) begin
        if (in_col < MaxW) rows[in_slot][in_col] = pix;
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_slot = (in_slot + 1) % 3;
          in_row++;
          if (in_row >= h) in_row = 0;
        end
        if (lead <= MaxW + 2) lead++;
        if (lead > w + 1) visit();
      end else begin
        total = w * h;
        pos = out_row * w + out_col;
        remain = pos < total ? total - pos : 1;
        if (lead > 0 && lead >= remain) visit();
      end
    endfunction

    function void check_result(logic [7:0] px, logic eor, logic eof);
      filt_out_t e;
      if (pend_q.size() == 0) begin
        $display("%0t: unexpected pixel_out=%0d eor=%0b eof=%0b", $time, px, eor, eof);
        errors++;
        return;
      end
      e = pend_q.pop_front();
      if (px !== e.px) begin
        $display("%0t: pixel_out expected %0d actual %0d", $time, e.px, px);
        errors++;
      end
      if (eor !== e.eor) begin
        $display("%0t: end_of_row expected %0b actual %0b", $time, e.eor, eor);
        errors++;
      end
      if (eof !== e.eof) begin
        $display("%0t: end_of_frame expected %0b actual %0b", $time, e.eof, eof);
        errors++;
      end
    endfunction
  endclass

  logic            clk;
  logic            rst;
  logic            cfg_we;
  logic [1:0]      cfg_index;
  logic [CfgW-1:0] cfg_data;
  logic            in_valid;
  logic            in_stall;
  logic            action;
  logic [7:0]      pixel;
  logic            out_valid;
  logic            out_stall;
  logic [7:0]      pixel_out;
  logic            end_of_row;
  logic            end_of_frame;

  filter_scoreboard sb;
  int  cycles;
  int  stall_left;
  bit  steady;
  int  pixels_sent;

  window3x3_image_filter u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .pixel(pixel),
    .out_valid(out_valid), .out_stall(out_stall), .pixel_out(pixel_out),
    .end_of_row(end_of_row), .end_of_frame(end_of_frame)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(pixel_out, end_of_row, end_of_frame);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_window3x3_image_filter: errors");
      $finish;
    end
  end

  // Entered and left at a falling edge.
  task automatic send_req(logic act, logic [7:0] px);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    pixel <= px;
    do @(posedge clk); while (in_stall);
    sb.note_request(act, px);
    if (act == 1'b0) pixels_sent++;
    @(negedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, int unsigned v);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[CfgW-1:0];
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pend_q.size() > 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic drain();
    while (sb.lead > 0) send_req(1'b1, 8'($urandom));
    send_req(1'b1, 8'($urandom));
  endtask

  task automatic run_phase(fmode_t fm, bmode_t bm, int unsigned wr, int unsigned hr,
                           int frames);
    int unsigned n;
    int style;
    logic [7:0] px;
    wait_idle();
    cfg_write(REG_FILTER_MODE, fm);
    cfg_write(REG_BORDER_MODE, bm);
    cfg_write(REG_IMAGE_WIDTH, wr);
    cfg_write(REG_IMAGE_HEIGHT, hr);
    steady = ($urandom_range(0, 4) == 0);
    n = sb.eff_w() * sb.eff_h();
    for (int f = 0; f < frames; f++) begin
      style = $urandom_range(0, 3);
      for (int unsigned i = 0; i < n; i++) begin
        // stray drain tick mid-frame, must be ignored
        if ($urandom_range(0, 19) == 0) send_req(1'b1, 8'($urandom));
        case (style)
          1: px = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          2: px = 8'($urandom_range(200, 255));
          default: px = 8'($urandom);
        endcase
        send_req(1'b0, px);
      end
    end
    drain();
  endtask

  initial begin
    int unsigned wr, hr;
    sb = new();
    cycles = 0;
    steady = 0;
    pixels_sent = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_FILTER_MODE;
    cfg_data = '0;
    in_valid = 1'b0;
    action = 1'b0;
    pixel = 8'd0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // drain tick with nothing pending, then a checkerboard 3x3 under reset modes
    send_req(1'b1, 8'd0);
    cfg_write(REG_IMAGE_WIDTH, 3);
    cfg_write(REG_IMAGE_HEIGHT, 3);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_req(1'b1, 8'd255);
      send_req(1'b0, i[0] ? 8'd255 : 8'd0);
    end
    drain();
    run_phase(FM_SOBEL, BM_PAD, 3, 3, 1);

    // every operator under every border mode, clamped small sizes included
    for (int k = 0; k < 32; k++) begin
      wr = $urandom_range(3, 6);
      hr = $urandom_range(3, 4);
      if ($urandom_range(0, 7) == 0) wr = $urandom_range(0, 2);
      if ($urandom_range(0, 7) == 0) hr = $urandom_range(0, 2);
      run_phase(fmode_t'(k % 8), bmode_t'(k / 8), wr, hr, (k % 4 == 0) ? 2 : 1);
    end
    while (pixels_sent < 600)
      run_phase(fmode_t'($urandom_range(0, 7)), bmode_t'($urandom_range(0, 3)),
                $urandom_range(3, 9), $urandom_range(3, 6), 1);

    wait_idle();
    if (sb.errors == 0) begin
      $display("tb_window3x3_image_filter: clean");
    end else begin
      $display("tb_window3x3_image_filter: errors");
    end
    $finish;
  end

endmodule
